// ===== design/tcfd_pkg.sv =====
// Shared types, character codes and keyword tables of the text command frame decoder.
package tcfd_pkg;

    localparam int MAX_FIELD_CHARS_DEF = 100;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    typedef enum logic [4:0] {
        PH_WAIT = 5'b00001,
        PH_NAME = 5'b00010,
        PH_ARG  = 5'b00100,
        PH_NUM  = 5'b01000,
        PH_END  = 5'b10000
    } frame_phase_t;

    typedef enum logic [3:0] {
        NP_BLANK  = 4'b0001,
        NP_SIGN   = 4'b0010,
        NP_DIGITS = 4'b0100,
        NP_DONE   = 4'b1000
    } num_phase_t;

    typedef enum logic [2:0] {
        KW_NONE  = 3'd0,
        KW_ON    = 3'd1,
        KW_OFF   = 3'd2,
        KW_BLINK = 3'd3,
        KW_DELAY = 3'd4
    } keyword_t;

    typedef enum logic [2:0] {
        ST_LED_ON    = 3'd0,
        ST_LED_OFF   = 3'd1,
        ST_BLINK_SET = 3'd2,
        ST_DELAY_SET = 3'd3,
        ST_BAD_ARG   = 3'd4
    } status_t;

    typedef struct packed {
        logic        fire;
        status_t     status;
        logic [1:0]  led_mode;
        logic [15:0] blink_rate;
        logic [31:0] loop_delay;
    } tcfd_result_t;

    // Characters of the command name, by position.
    function automatic logic [7:0] led_char(input logic [1:0] pos);
        case (pos)
            2'd0:    led_char = 8'h4C;
            2'd1:    led_char = 8'h45;
            2'd2:    led_char = 8'h44;
            default: led_char = 8'h00;
        endcase
    endfunction

    // Keyword table: 0 ON, 1 OFF, 2 BLINK, 3 DELAY.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [39:0] row;
        case (k)
            2'd0:    row = {8'h00, 8'h00, 8'h00, 8'h4E, 8'h4F};
            2'd1:    row = {8'h00, 8'h00, 8'h46, 8'h46, 8'h4F};
            2'd2:    row = {8'h4B, 8'h4E, 8'h49, 8'h4C, 8'h42};
            default: row = {8'h59, 8'h41, 8'h4C, 8'h45, 8'h44};
        endcase
        case (pos)
            3'd0:    kw_char = row[7:0];
            3'd1:    kw_char = row[15:8];
            3'd2:    kw_char = row[23:16];
            3'd3:    kw_char = row[31:24];
            3'd4:    kw_char = row[39:32];
            default: kw_char = 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            2'd0:    kw_len = 3'd2;
            2'd1:    kw_len = 3'd3;
            default: kw_len = 3'd5;
        endcase
    endfunction

    function automatic keyword_t kw_code(input logic [1:0] k);
        case (k)
            2'd0:    kw_code = KW_ON;
            2'd1:    kw_code = KW_OFF;
            2'd2:    kw_code = KW_BLINK;
            default: kw_code = KW_DELAY;
        endcase
    endfunction

endpackage

// ===== design/tcfd_core.sv =====
// Frame parser state, command registers and per-byte next-state logic.
module tcfd_core
    import tcfd_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    output tcfd_result_t result
);

    localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELD_CHARS);
    localparam logic [CNT_W-1:0] LED_LEN = CNT_W'(3);

    frame_phase_t     frame_phase_reg, frame_phase_next;
    logic [CNT_W-1:0] field_count_reg, field_count_next;
    logic             name_prefix_ok_reg, name_prefix_ok_next;
    logic             name_is_led_reg, name_is_led_next;
    logic [3:0]       arg_cand_reg, arg_cand_next;
    keyword_t         arg_keyword_reg, arg_keyword_next;
    num_phase_t       num_phase_reg, num_phase_next;
    logic             num_negative_reg, num_negative_next;
    logic [31:0]      num_value_reg, num_value_next;
    logic             field_closed_reg, field_closed_next;
    logic [1:0]       mode_reg, mode_next;
    logic [15:0]      rate_reg, rate_next;
    logic [31:0]      delay_reg, delay_next;

    always_comb
    begin
        logic [31:0]      num;
        logic [31:0]      digit;
        logic             is_digit;
        logic             has_room;
        logic [CNT_W-1:0] cnt_plus;
        logic [CNT_W-1:0] len_k;
        logic             keep;

        frame_phase_next    = frame_phase_reg;
        field_count_next    = field_count_reg;
        name_prefix_ok_next = name_prefix_ok_reg;
        name_is_led_next    = name_is_led_reg;
        arg_cand_next       = arg_cand_reg;
        arg_keyword_next    = arg_keyword_reg;
        num_phase_next      = num_phase_reg;
        num_negative_next   = num_negative_reg;
        num_value_next      = num_value_reg;
        field_closed_next   = field_closed_reg;
        mode_next           = mode_reg;
        rate_next           = rate_reg;
        delay_next          = delay_reg;

        result.fire   = 1'b0;
        result.status = ST_BAD_ARG;

        num      = num_negative_reg ? (32'd0 - num_value_reg) : num_value_reg;
        digit    = {28'd0, rx_byte[3:0]};
        is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
        has_room = field_count_reg < MAX_CNT;
        cnt_plus = field_count_reg + 1'b1;
        len_k    = '0;
        keep     = 1'b0;

        if (rx_byte == CH_SEMI)
        begin
            result.fire = name_is_led_reg &&
                          (frame_phase_reg inside {PH_ARG, PH_NUM, PH_END});
            if (result.fire)
            begin
                case (arg_keyword_reg)
                    KW_ON:
                    begin
                        mode_next     = MODE_ON;
                        result.status = ST_LED_ON;
                    end
                    KW_OFF:
                    begin
                        mode_next     = MODE_OFF;
                        result.status = ST_LED_OFF;
                    end
                    KW_BLINK:
                    begin
                        mode_next     = MODE_BLINK;
                        rate_next     = (num[15:0] == 16'd0) ? 16'd1 : num[15:0];
                        result.status = ST_BLINK_SET;
                    end
                    KW_DELAY:
                    begin
                        delay_next    = num;
                        result.status = ST_DELAY_SET;
                    end
                    default:
                    begin
                        result.status = ST_BAD_ARG;
                    end
                endcase
            end
            // Every semicolon ends the frame.
            frame_phase_next    = PH_WAIT;
            field_count_next    = '0;
            name_prefix_ok_next = 1'b0;
            name_is_led_next    = 1'b0;
            arg_cand_next       = 4'hF;
            arg_keyword_next    = KW_NONE;
            num_phase_next      = NP_BLANK;
            num_negative_next   = 1'b0;
            num_value_next      = '0;
            field_closed_next   = 1'b0;
        end
        else if (!(rx_byte inside {CH_SPACE, CH_CR, CH_LF}))
        begin
            case (frame_phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]})
                    begin
                        // First name character: the field count restarts at one.
                        frame_phase_next    = PH_NAME;
                        field_count_next    = CNT_W'(1);
                        field_closed_next   = 1'b0;
                        name_prefix_ok_next = (rx_byte == led_char(2'd0));
                        name_is_led_next    = 1'b0;
                    end
                end
                PH_NAME:
                begin
                    if (rx_byte == CH_LBRACK)
                    begin
                        frame_phase_next  = PH_ARG;
                        field_count_next  = '0;
                        field_closed_next = 1'b0;
                    end
                    else if (has_room)
                    begin
                        field_count_next = cnt_plus;
                        if (!field_closed_reg)
                        begin
                            if (rx_byte == CH_NUL)
                            begin
                                field_closed_next = 1'b1;
                            end
                            else
                            begin
                                name_prefix_ok_next = name_prefix_ok_reg &&
                                    (field_count_reg < LED_LEN) &&
                                    (rx_byte == led_char(field_count_reg[1:0]));
                                name_is_led_next = name_prefix_ok_next &&
                                    (cnt_plus == LED_LEN);
                            end
                        end
                    end
                end
                PH_ARG:
                begin
                    if (rx_byte == CH_RBRACK)
                    begin
                        frame_phase_next = PH_END;
                    end
                    else if (rx_byte == CH_COMMA)
                    begin
                        frame_phase_next  = PH_NUM;
                        field_count_next  = '0;
                        field_closed_next = 1'b0;
                    end
                    else if (has_room)
                    begin
                        field_count_next = cnt_plus;
                        if (!field_closed_reg)
                        begin
                            if (rx_byte == CH_NUL)
                            begin
                                field_closed_next = 1'b1;
                            end
                            else
                            begin
                                arg_keyword_next = KW_NONE;
                                for (int k = 0; k < 4; k++)
                                begin
                                    len_k = CNT_W'(kw_len(2'(k)));
                                    keep  = (field_count_reg < len_k) &&
                                            (rx_byte == kw_char(2'(k),
                                                                field_count_reg[2:0]));
                                    if (!keep)
                                    begin
                                        arg_cand_next[k] = 1'b0;
                                    end
                                    else if (arg_cand_reg[k] && (cnt_plus == len_k))
                                    begin
                                        arg_keyword_next = kw_code(2'(k));
                                    end
                                end
                            end
                        end
                    end
                end
                PH_NUM:
                begin
                    if (rx_byte == CH_RBRACK)
                    begin
                        frame_phase_next = PH_END;
                    end
                    else if (has_room)
                    begin
                        field_count_next = cnt_plus;
                        case (num_phase_reg)
                            NP_BLANK:
                            begin
                                if (rx_byte inside {[8'h09:8'h0D]})
                                begin
                                    num_phase_next = NP_BLANK;
                                end
                                else if (rx_byte == CH_PLUS)
                                begin
                                    num_phase_next = NP_SIGN;
                                end
                                else if (rx_byte == CH_MINUS)
                                begin
                                    num_negative_next = 1'b1;
                                    num_phase_next    = NP_SIGN;
                                end
                                else if (is_digit)
                                begin
                                    num_value_next = digit;
                                    num_phase_next = NP_DIGITS;
                                end
                                else
                                begin
                                    num_phase_next = NP_DONE;
                                end
                            end
                            NP_SIGN, NP_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    num_value_next = (num_value_reg << 3) +
                                                     (num_value_reg << 1) + digit;
                                    num_phase_next = NP_DIGITS;
                                end
                                else
                                begin
                                    num_phase_next = NP_DONE;
                                end
                            end
                            default:
                            begin
                                num_phase_next = num_phase_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    frame_phase_next = frame_phase_reg;
                end
            endcase
        end

        result.led_mode   = mode_next;
        result.blink_rate = rate_next;
        result.loop_delay = delay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase_reg    <= PH_WAIT;
            field_count_reg    <= '0;
            name_prefix_ok_reg <= 1'b0;
            name_is_led_reg    <= 1'b0;
            arg_cand_reg       <= 4'hF;
            arg_keyword_reg    <= KW_NONE;
            num_phase_reg      <= NP_BLANK;
            num_negative_reg   <= 1'b0;
            num_value_reg      <= '0;
            field_closed_reg   <= 1'b0;
            mode_reg           <= MODE_OFF;
            rate_reg           <= 16'd1;
            delay_reg          <= '0;
        end
        else if (step_en)
        begin
            frame_phase_reg    <= frame_phase_next;
            field_count_reg    <= field_count_next;
            name_prefix_ok_reg <= name_prefix_ok_next;
            name_is_led_reg    <= name_is_led_next;
            arg_cand_reg       <= arg_cand_next;
            arg_keyword_reg    <= arg_keyword_next;
            num_phase_reg      <= num_phase_next;
            num_negative_reg   <= num_negative_next;
            num_value_reg      <= num_value_next;
            field_closed_reg   <= field_closed_next;
            mode_reg           <= mode_next;
            rate_reg           <= rate_next;
            delay_reg          <= delay_next;
        end
    end

    // An exact name match always implies the prefix still matches.
    a_led_implies_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        name_is_led_reg |-> name_prefix_ok_reg)
        else $error("name match flag set without matching prefix");

    // The blink rate register never holds zero.
    a_rate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rate_reg != 16'd0)
        else $error("blink rate register is zero");

    // The field count never passes the field limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_count_reg <= MAX_CNT)
        else $error("field count beyond limit");

    // A recognized keyword is still among the remaining candidates.
    a_keyword_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        (arg_keyword_reg == KW_ON    && !arg_cand_reg[0]) ||
        (arg_keyword_reg == KW_OFF   && !arg_cand_reg[1]) ||
        (arg_keyword_reg == KW_BLINK && !arg_cand_reg[2]) ||
        (arg_keyword_reg == KW_DELAY && !arg_cand_reg[3]) |-> 1'b0)
        else $error("keyword selected after its candidate was dropped");

endmodule

// ===== design/text_command_frame_decoder_unit.sv =====
// Top level of the text command frame decoder: stream ports, byte and result registers.
// Timing: an accepted byte waits in the byte register and is parsed from it once the
// result slot is free or being emptied; its command result is then registered onto m_tvalid.
// Throughput: one byte per cycle; the parser updates all its flags and the number
// accumulator in a single pass, so only a stalled result slot holds up the input.
// Reset: rst_n is asynchronous and active low; it empties both registers, returns the
// parser to waiting for a frame, and sets LED off, blink rate 1 and loop delay 0.
module text_command_frame_decoder_unit
    import tcfd_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[2:0], led_mode[4:3], blink_rate[20:5],
                                   // loop_delay[52:21], zero fill[55:53]
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    tcfd_result_t out_result_reg;
    tcfd_result_t core_result;
    logic         advance;

    // The byte register moves into the parser whenever the result slot is free
    // or is being emptied in this cycle, so the two sides stream independently.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    tcfd_core #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // Only a semicolon that completes an LED command produces a result transaction;
    // every other byte passes through the parser and leaves the slot empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= core_result.fire;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_result.fire)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.loop_delay,
                       out_result_reg.blink_rate,
                       out_result_reg.led_mode,
                       out_result_reg.status};

endmodule

// ===== tb/sv/command_check_pkg.sv =====
// Report layout, keyword table and scoreboard used by the command frame decoder testbench.
`timescale 1ns / 1ps
package command_check_pkg;
    import tcfd_pkg::*;

    localparam int FIELD_LIMIT = MAX_FIELD_CHARS_DEF;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // Layout of m_tdata; the last member sits in the lowest bits.
    typedef struct packed {
        logic [2:0]  zero_fill;
        logic [31:0] loop_delay;
        logic [15:0] blink_rate;
        logic [1:0]  led_mode;
        status_t     status;
    } report_t;

    // Argument keywords by table index: text and the code that a full match selects.
    function automatic void keyword_entry(input int unsigned k, output string txt,
                                          output keyword_t code);
        case (k)
            0:
            begin
                txt  = "ON";
                code = KW_ON;
            end
            1:
            begin
                txt  = "OFF";
                code = KW_OFF;
            end
            2:
            begin
                txt  = "BLINK";
                code = KW_BLINK;
            end
            default:
            begin
                txt  = "DELAY";
                code = KW_DELAY;
            end
        endcase
    endfunction

    class command_scoreboard;
        string        command_name = "LED";
        frame_phase_t phase;
        int unsigned  field_len;
        bit           field_ended;
        bit           name_prefix_ok;
        bit           name_is_led;
        bit [3:0]     arg_candidates;
        keyword_t     arg_keyword;
        num_phase_t   num_phase;
        bit           num_negative;
        logic [31:0]  num_value;
        logic [1:0]   led_mode;
        logic [15:0]  blink_rate;
        logic [31:0]  loop_delay;
        report_t      queued_reports[$];
        int           fail_count;
        int           reports_checked;

        function new();
            clear_frame();
            led_mode        = MODE_OFF;
            blink_rate      = 16'd1;
            loop_delay      = '0;
            fail_count      = 0;
            reports_checked = 0;
        endfunction

        function void clear_frame();
            phase          = PH_WAIT;
            field_len      = 0;
            field_ended    = 1'b0;
            name_prefix_ok = 1'b0;
            name_is_led    = 1'b0;
            arg_candidates = 4'hF;
            arg_keyword    = KW_NONE;
            num_phase      = NP_BLANK;
            num_negative   = 1'b0;
            num_value      = '0;
        endfunction

        function void open_field(frame_phase_t next);
            phase       = next;
            field_len   = 0;
            field_ended = 1'b0;
        endfunction

        function void name_add(logic [7:0] c);
            int unsigned pos;
            pos = field_len;
            if (pos >= FIELD_LIMIT)
                return;
            field_len = pos + 1;
            if (field_ended)
                return;
            if (c == CH_NUL)
            begin
                field_ended = 1'b1;
                return;
            end
            name_prefix_ok = name_prefix_ok && pos < 3 && c == command_name[pos];
            name_is_led    = name_prefix_ok && pos == 2;
        endfunction

        function void arg_add(logic [7:0] c);
            int unsigned pos;
            string       txt;
            keyword_t    code;
            bit          keep;
            pos = field_len;
            if (pos >= FIELD_LIMIT)
                return;
            field_len = pos + 1;
            if (field_ended)
                return;
            if (c == CH_NUL)
            begin
                field_ended = 1'b1;
                return;
            end
            arg_keyword = KW_NONE;
            for (int unsigned k = 0; k < 4; k++)
            begin
                keyword_entry(k, txt, code);
                keep = pos < txt.len() && c == txt[pos];
                if (!keep)
                    arg_candidates[k] = 1'b0;
                else if (arg_candidates[k] && txt.len() == pos + 1)
                    arg_keyword = code;
            end
        endfunction

        function void num_add(logic [7:0] c);
            bit is_digit;
            is_digit = c >= "0" && c <= "9";
            if (field_len >= FIELD_LIMIT)
                return;
            field_len = field_len + 1;
            case (num_phase)
                NP_BLANK:
                begin
                    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
                        ;
                    else if (c == CH_PLUS)
                        num_phase = NP_SIGN;
                    else if (c == CH_MINUS)
                    begin
                        num_negative = 1'b1;
                        num_phase    = NP_SIGN;
                    end
                    else if (is_digit)
                    begin
                        num_value = {24'd0, c - 8'h30};
                        num_phase = NP_DIGITS;
                    end
                    else
                        num_phase = NP_DONE;
                end
                NP_SIGN, NP_DIGITS:
                begin
                    if (is_digit)
                    begin
                        num_value = num_value * 32'd10 + {24'd0, c - 8'h30};
                        num_phase = NP_DIGITS;
                    end
                    else
                        num_phase = NP_DONE;
                end
                default:
                    ;
            endcase
        endfunction

        function void run_command();
            logic [31:0] value;
            report_t     rpt;
            value = num_negative ? 32'd0 - num_value : num_value;
            case (arg_keyword)
                KW_ON:
                begin
                    led_mode   = MODE_ON;
                    rpt.status = ST_LED_ON;
                end
                KW_OFF:
                begin
                    led_mode   = MODE_OFF;
                    rpt.status = ST_LED_OFF;
                end
                KW_BLINK:
                begin
                    led_mode   = MODE_BLINK;
                    blink_rate = value[15:0];
                    if (blink_rate == 16'd0)
                        blink_rate = 16'd1;
                    rpt.status = ST_BLINK_SET;
                end
                KW_DELAY:
                begin
                    loop_delay = value;
                    rpt.status = ST_DELAY_SET;
                end
                default:
                    rpt.status = ST_BAD_ARG;
            endcase
            rpt.led_mode   = led_mode;
            rpt.blink_rate = blink_rate;
            rpt.loop_delay = loop_delay;
            rpt.zero_fill  = '0;
            queued_reports.push_back(rpt);
        endfunction

        // Advances the frame parser by one accepted byte.
        function void decode_byte(logic [7:0] c);
            if (c == CH_SEMI)
            begin
                if (name_is_led && (phase == PH_ARG || phase == PH_NUM || phase == PH_END))
                    run_command();
                clear_frame();
            end
            else if (c != CH_SPACE && c != CH_CR && c != CH_LF)
            begin
                case (phase)
                    PH_WAIT:
                    begin
                        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
                        begin
                            open_field(PH_NAME);
                            name_prefix_ok = 1'b1;
                            name_add(c);
                        end
                    end
                    PH_NAME:
                    begin
                        if (c == CH_LBRACK)
                            open_field(PH_ARG);
                        else
                            name_add(c);
                    end
                    PH_ARG:
                    begin
                        if (c == CH_RBRACK)
                            phase = PH_END;
                        else if (c == CH_COMMA)
                            open_field(PH_NUM);
                        else
                            arg_add(c);
                    end
                    PH_NUM:
                    begin
                        if (c == CH_RBRACK)
                            phase = PH_END;
                        else
                            num_add(c);
                    end
                    default:
                        ;
                endcase
            end
        endfunction

        function int pending();
            return queued_reports.size();
        endfunction

        function void check_field(string field, longint unsigned want, longint unsigned seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
                fail_count++;
            end
        endfunction

        function void match_report(logic [55:0] word);
            report_t seen;
            report_t want;
            seen = word;
            reports_checked++;
            if (queued_reports.size() == 0)
            begin
                $error("report 0x%h arrived with no command pending", word);
                fail_count++;
                return;
            end
            want = queued_reports.pop_front();
            check_field("status", want.status, seen.status);
            check_field("led_mode", want.led_mode, seen.led_mode);
            check_field("blink_rate", want.blink_rate, seen.blink_rate);
            check_field("loop_delay", want.loop_delay, seen.loop_delay);
            check_field("zero_fill", want.zero_fill, seen.zero_fill);
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the text command frame decoder driven over its byte stream.
`timescale 1ns / 1ps
module testbench;
    import tcfd_pkg::*;
    import command_check_pkg::*;

    // The random part stops once this many significant bytes went in; together with
    // the directed frames the run sends about nineteen hundred bytes.
    localparam int RANDOM_ITEMS   = 1500;
    // A byte is parsed from the byte register and its result registered after that; the spare
    // cycles at the end catch any report that should never have come.
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // status[2:0], led_mode[4:3], blink_rate[20:5],
                                   // loop_delay[52:21], zero fill[55:53]

    command_scoreboard sb;
    logic [7:0]  byte_queue[$];
    int unsigned blank_pct     = 0;
    int unsigned stim_count    = 0;
    int unsigned stalled_cycles = 0;
    bit          tx_quiet      = 1'b0;
    bit          rx_quiet      = 1'b0;
    bit          drain_mode    = 1'b0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_roll;
    logic        rx_ready_next;

    text_command_frame_decoder_unit #(
        .MAX_FIELD_CHARS(FIELD_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The report side mostly accepts, stalls now and then in short bursts and rarely for
    // a long stretch. During quiet stretches and the final drain it never stalls.
    always @(posedge clk)
    begin
        if (drain_mode || rx_quiet)
            rx_ready_next = 1'b1;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            rx_ready_next = 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 10)
            begin
                rx_stall_left = $urandom_range(0, 2);
                rx_ready_next = 1'b0;
            end
            else if (rx_roll < 13)
            begin
                rx_stall_left = $urandom_range(8, 30);
                rx_ready_next = 1'b0;
            end
            else
                rx_ready_next = 1'b1;
        end
        m_tready <= rx_ready_next;
    end

    // Every accepted report is checked against the oldest prediction. The watchdog
    // ends the run if neither side completes a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.match_report(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles = stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drops tvalid unless it is already low, so a step never sees two updates.
    task release_input();
        if (s_tvalid)
            s_tvalid <= 1'b0;
    endtask

    // Presents one byte and holds it until the transaction completes; the byte is
    // handed to the predictor at the accepting edge, in this same process.
    task send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.decode_byte(b);
    endtask

    // Mostly back to back, often a short gap, now and then a long one.
    task idle_gap();
        int unsigned roll;
        int unsigned cycles;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            cycles = 0;
        else if (roll < 93)
            cycles = $urandom_range(1, 3);
        else
            cycles = $urandom_range(10, 40);
        if (cycles != 0)
        begin
            release_input();
            repeat (cycles) @(posedge clk);
        end
    endtask

    // The sender holds off until every predicted report has been accepted. It always
    // waits on the clock first, so the dropped tvalid settles before the next byte.
    task wait_for_reports();
        release_input();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Queues a character, sometimes behind a space, CR or LF that the block drops.
    task push_char(input logic [7:0] c);
        if (blank_pct != 0 && $urandom_range(0, 99) < blank_pct)
        begin
            case ($urandom_range(0, 2))
                0:       byte_queue.push_back(CH_SPACE);
                1:       byte_queue.push_back(CH_CR);
                default: byte_queue.push_back(CH_LF);
            endcase
        end
        byte_queue.push_back(c);
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Letters that keep keyword matching alive for a while before it breaks.
    function automatic logic [7:0] arg_letter();
        string pool;
        pool = "ONFBLIKDAYEX";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task send_queued();
        logic [7:0] b;
        while (byte_queue.size() > 0)
        begin
            b = byte_queue.pop_front();
            if (b != CH_SPACE && b != CH_CR && b != CH_LF)
                stim_count++;
            send_byte(b);
            if (!tx_quiet)
                idle_gap();
        end
    endtask

    // Number text as atoi sees it: optional leading tab, VT or FF, an optional sign,
    // digit strings from empty to far beyond 32 bits, and sometimes trailing junk.
    task push_number();
        int unsigned roll;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 2))
                    0:       push_char(CH_TAB);
                    1:       push_char(CH_VT);
                    default: push_char(CH_FF);
                endcase
            end
        end
        roll = $urandom_range(0, 9);
        if (roll < 2)
            push_char(CH_MINUS);
        else if (roll == 2)
            push_char(CH_PLUS);
        case ($urandom_range(0, 9))
            0:       ;
            1:       push_text("0");
            2:       push_text("65535");
            3:       push_text("65536");
            4:       push_text("4294967295");
            5:       repeat ($urandom_range(11, 16)) push_char(8'("0" + $urandom_range(0, 9)));
            6, 7:    push_text($sformatf("%0d", $urandom));
            default: push_text($sformatf("%0d", $urandom_range(0, 999)));
        endcase
        if ($urandom_range(0, 6) == 0)
        begin
            push_char(arg_letter());
            push_text("42");
        end
    endtask

    // A mostly well-formed command frame with random content.
    task compose_command();
        int unsigned k;
        int unsigned roll;
        string       txt;
        keyword_t    code;
        bit          keyword_arg;
        logic [7:0]  junk;
        if ($urandom_range(0, 99) < 88)
            push_text("LED");
        else
        begin
            case ($urandom_range(0, 4))
                0:       push_text("led");
                1:       push_text("LEDX");
                2:       push_text("LE");
                3:       push_text("XLED");
                default: repeat ($urandom_range(1, 5)) push_char(8'("A" + $urandom_range(0, 25)));
            endcase
        end
        if ($urandom_range(0, 99) < 95)
            push_char(CH_LBRACK);
        roll = $urandom_range(0, 99);
        k = roll < 20 ? 0 : roll < 40 ? 1 : roll < 70 ? 2 : 3;
        keyword_entry(k, txt, code);
        keyword_arg = $urandom_range(0, 99) < 85;
        if (keyword_arg)
        begin
            push_text(txt);
            // A zero byte ends the keyword string; what follows must not matter.
            if ($urandom_range(0, 19) == 0)
            begin
                push_char(CH_NUL);
                push_char(arg_letter());
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(0, 6)) push_char(arg_letter());
                3, 4:    push_text(txt.substr(0, txt.len() - 2));
                5, 6:
                begin
                    push_text(txt);
                    push_char(arg_letter());
                end
                7, 8:
                begin
                    push_text(txt);
                    push_char(CH_NUL);
                    push_text("ON");
                end
                default: repeat ($urandom_range(95, 110)) push_char(arg_letter());
            endcase
        end
        if ($urandom_range(0, 99) < ((keyword_arg && (code == KW_BLINK || code == KW_DELAY))
                                     ? 80 : 15))
        begin
            push_char(CH_COMMA);
            push_number();
        end
        if ($urandom_range(0, 99) < 85)
        begin
            push_char(CH_RBRACK);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    junk = 8'($urandom_range(0, 255));
                    if (junk == CH_SEMI)
                        junk = CH_COMMA;
                    push_char(junk);
                end
            end
        end
        if ($urandom_range(0, 99) < 97)
            push_char(CH_SEMI);
    endtask

    // Short runs of frame punctuation and keyword letters in random order.
    task compose_broken();
        string       pool;
        int unsigned roll;
        pool = "LED[],;ONFBLIKDAY0129-+x";
        repeat ($urandom_range(1, 15))
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                push_char(CH_NUL);
            else if (roll == 1)
                push_char(CH_TAB);
            else
                push_char(pool[$urandom_range(0, pool.len() - 1)]);
        end
        if ($urandom_range(0, 4) != 0)
            push_char(CH_SEMI);
    endtask

    task compose_noise();
        repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0)
            push_char(CH_SEMI);
    endtask

    // Directed frames: every keyword, the extremes of the number and of the byte
    // value, and each corner of the frame syntax.
    task run_directed();
        push_text("LED[ON];");
        push_text("LED[OFF];");
        // Dropped characters inside the name.
        push_text("L E D");
        push_char(CH_CR);
        push_char(CH_LF);
        push_text("[BLINK,250];");
        // A zero rate turns into one; minus one gives the largest rate.
        push_text("LED[BLINK,0];LED[BLINK,-1];");
        // Largest delay, then one past it, which wraps to zero.
        push_text("LED[DELAY,4294967295];LED[DELAY,4294967296];LED[DELAY,-7];");
        push_text("LED[XYZ];LED[];");
        // Semicolon while waiting and again inside the name: nothing runs.
        push_text(";LED;");
        push_text("LEDS[ON];led[ON];");
        // Keyword without its number.
        push_text("LED[BLINK];LED[DELAY];");
        // No closing bracket before the semicolon.
        push_text("LED[ON;LED[DELAY,12;");
        // Number field longer than the field limit: only the first characters count.
        push_text("LED[DELAY,");
        repeat (FIELD_LIMIT - 1) push_char(CH_TAB);
        push_text("57];");
        // Zero bytes close the name and the argument.
        push_text("LED");
        push_char(CH_NUL);
        push_text("X[OFF");
        push_char(CH_NUL);
        push_text("ON];");
        // Leading tab, VT and FF, a sign, and a stray letter that ends the digits.
        push_text("LED[DELAY,");
        push_char(CH_TAB);
        push_char(CH_VT);
        push_char(CH_FF);
        push_text("-12a3];LED[DELAY,+-5];");
        // Bytes after the closing bracket are ignored.
        push_text("LED[BLINK,9]x,7[;");
        // Extreme byte values and a digit never start a frame.
        push_char(8'hFF);
        push_char(CH_NUL);
        push_text("1[ON];");
        send_queued();
    endtask

    initial
    begin
        int unsigned roll;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_reports();

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            blank_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
            tx_quiet  = $urandom_range(0, 7) == 0;
            rx_quiet  = $urandom_range(0, 7) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                compose_command();
            else if (roll < 90)
                compose_broken();
            else
                compose_noise();
            send_queued();
            if ($urandom_range(0, 39) == 0)
                wait_for_reports();
        end

        // Let every outstanding report come out, then watch a little longer for
        // any report that no command asked for.
        drain_mode = 1'b1;
        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
